/* hdl/arsb_pkg.sv */
// Package for the address range segment buffer.
// Holds command and result codes, payload structs and controller/datapath signals.
// No dependencies.
package arsb_pkg;

  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = 6;
  localparam logic [CfgIdxW-1:0] CFG_RANGE_COUNT = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_BUFFER_LIMIT = 1'd1;

  localparam logic [1:0] CMD_DATA = 2'd0;
  localparam logic [1:0] CMD_END = 2'd1;
  localparam logic [1:0] CMD_LOAD = 2'd2;

  localparam logic [1:0] KIND_SEG = 2'd0;
  localparam logic [1:0] KIND_ACC = 2'd1;
  localparam logic [1:0] KIND_REJ = 2'd2;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] address;
    logic [7:0]  data_byte;
    logic [2:0]  entry_index;
    logic [31:0] entry_start;
    logic [31:0] entry_length;
    logic        entry_relative;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  range_slot;
    logic [31:0] segment_address;
    logic [7:0]  data_out;
    logic        last;
  } out_item_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic capture;     // register the input request
    logic search_step; // examine one slot during a range search
    logic search_init; // start a range search
    logic open_range;  // open the found range
    logic close_range;
    logic append;      // write the byte into the buffer
    logic load_commit; // store the checked entry
    logic set_bad;
    logic flush_start; // begin draining the buffer
    logic flush_step;  // one byte handed to output
  } ctrl_t;

  // Datapath to controller status.
  typedef struct packed {
    logic [1:0] cmd;
    logic       table_bad;
    logic       range_open;
    logic       addr_match;  // byte continues the open range
    logic       search_done;
    logic       search_hit;
    logic       full_before; // buffer at capacity before append
    logic       hit_limit;   // after append: limit reached
    logic       range_end;   // after append: range exhausted
    logic       fill_zero;
    logic       flush_last;  // current drain byte is the last one
    logic       load_bad;
    logic       load_ignore;
  } stat_t;

endpackage

/* hdl/arsb_ram.sv */
// Generic single-port-write RAM with registered read.
// No dependencies.
module arsb_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

/* hdl/arsb_datapath.sv */
// Datapath: range table, range search, offset, fill count, byte buffer.
// Depends on arsb_pkg and arsb_ram.
module arsb_datapath import arsb_pkg::*; #(
  parameter int unsigned RangeSlots = 8,
  parameter int unsigned BufferBytes = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_item_t  in_i,
  input  logic [3:0] range_count_i,
  input  logic [5:0] buffer_limit_i,
  input  ctrl_t     ctrl_i,
  output stat_t     stat_o,
  output out_item_t out_o
);
  localparam int unsigned SlotW = (RangeSlots > 1) ? $clog2(RangeSlots) : 1;
  localparam int unsigned BufW = (BufferBytes > 1) ? $clog2(BufferBytes) : 1;
  localparam int unsigned CntW = $clog2(BufferBytes + 1);

  in_item_t req_q;
  logic [31:0] start_q [RangeSlots];
  logic [31:0] len_q [RangeSlots];
  logic [RangeSlots-1:0] rel_q, wr_q;
  logic table_bad_q, open_q;
  logic [SlotW-1:0] act_q, srch_q;
  logic srch_done_q, srch_hit_q;
  logic [31:0] off_q;
  logic [CntW-1:0] fill_q, rd_q;
  logic [31:0] seg_addr_q;

  logic [SlotW-1:0] ri;
  logic [3:0] eff_cnt;
  logic [CntW-1:0] eff_lim;
  logic [32:0] act_end, srch_end;
  logic prev_bad, next_bad;
  logic [7:0] rdata;

  assign ri = req_q.entry_index[SlotW-1:0];
  assign eff_cnt = (range_count_i > 4'(RangeSlots)) ? 4'(RangeSlots) : range_count_i;
  always_comb begin
    if (buffer_limit_i == '0) eff_lim = CntW'(1);
    else if (7'(buffer_limit_i) > 7'(BufferBytes)) eff_lim = CntW'(BufferBytes);
    else eff_lim = CntW'(buffer_limit_i);
  end

  assign srch_end = {1'b0, start_q[srch_q]} + {1'b0, len_q[srch_q]};
  assign act_end = {1'b0, start_q[act_q]} + {1'b0, off_q};

  // Neighbour checks for a load.
  always_comb begin
    prev_bad = 1'b0;
    next_bad = 1'b0;
    if (32'(req_q.entry_index) > 0 && 32'(req_q.entry_index) <= RangeSlots) begin
      if (wr_q[ri - 1'b1]) begin
        prev_bad = (start_q[ri - 1'b1] >= req_q.entry_start) ||
          ({1'b0, start_q[ri - 1'b1]} + {1'b0, len_q[ri - 1'b1]} > {1'b0, req_q.entry_start});
      end
    end
    if (32'(req_q.entry_index) + 1 < RangeSlots) begin
      if (wr_q[ri + 1'b1]) begin
        next_bad = (req_q.entry_start >= start_q[ri + 1'b1]) ||
          ({1'b0, req_q.entry_start} + {1'b0, req_q.entry_length} >
           {1'b0, start_q[ri + 1'b1]});
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      table_bad_q <= 1'b0;
      open_q <= 1'b0;
      act_q <= '0;
      off_q <= '0;
      fill_q <= '0;
      rd_q <= '0;
      srch_q <= '0;
      srch_done_q <= 1'b0;
      srch_hit_q <= 1'b0;
    end else begin
      if (ctrl_i.capture) req_q <= in_i;
      if (ctrl_i.search_init) begin
        srch_q <= '0;
        srch_hit_q <= 1'b0;
        srch_done_q <= (eff_cnt == 4'd0);
      end else if (ctrl_i.search_step && !srch_done_q) begin
        // First slot whose end lies above the address decides the search.
        if (srch_end > {1'b0, req_q.address}) begin
          srch_done_q <= 1'b1;
          srch_hit_q <= (start_q[srch_q] <= req_q.address);
        end else if (32'(srch_q) + 1 >= 32'(eff_cnt)) begin
          srch_done_q <= 1'b1;
        end else begin
          srch_q <= srch_q + 1'b1;
        end
      end
      if (ctrl_i.open_range) begin
        open_q <= 1'b1;
        act_q <= srch_q;
        off_q <= req_q.address - start_q[srch_q];
        fill_q <= '0;
      end
      if (ctrl_i.append) begin
        fill_q <= fill_q + 1'b1;
        off_q <= off_q + 32'd1;
      end
      if (ctrl_i.flush_start) begin
        rd_q <= '0;
        seg_addr_q <= (off_q - 32'(fill_q)) + (rel_q[act_q] ? 32'd0 : start_q[act_q]);
      end
      if (ctrl_i.flush_step) begin
        rd_q <= rd_q + 1'b1;
        if (rd_q + 1'b1 == fill_q) fill_q <= '0;
      end
      if (ctrl_i.close_range) begin
        open_q <= 1'b0;
        act_q <= '0;
        off_q <= '0;
        fill_q <= '0;
      end
      if (ctrl_i.set_bad) table_bad_q <= 1'b1;
      if (ctrl_i.load_commit) begin
        start_q[ri] <= req_q.entry_start;
        len_q[ri] <= req_q.entry_length;
        rel_q[ri] <= req_q.entry_relative;
        wr_q[ri] <= 1'b1;
      end
    end
  end

  // The first byte of a drain is read while the read pointer is being cleared.
  arsb_ram #(.Width(8), .Depth(BufferBytes)) u_buf (
    .clk_i   (clk_i),
    .we_i    (ctrl_i.append),
    .waddr_i (fill_q[BufW-1:0]),
    .wdata_i (req_q.data_byte),
    .raddr_i (ctrl_i.flush_start ? BufW'(0) :
              (ctrl_i.flush_step ? BufW'(rd_q + 1'b1) : BufW'(rd_q))),
    .rdata_o (rdata)
  );

  always_comb begin
    stat_o.cmd = req_q.cmd;
    stat_o.table_bad = table_bad_q;
    stat_o.range_open = open_q;
    stat_o.addr_match = (act_end == {1'b0, req_q.address});
    stat_o.search_done = srch_done_q;
    stat_o.search_hit = srch_hit_q;
    stat_o.full_before = (fill_q >= CntW'(BufferBytes));
    stat_o.hit_limit = (fill_q >= eff_lim);
    stat_o.range_end = (off_q == len_q[act_q]);
    stat_o.fill_zero = (fill_q == '0);
    stat_o.flush_last = (rd_q + 1'b1 == fill_q);
    stat_o.load_bad = prev_bad || next_bad;
    stat_o.load_ignore = (32'(req_q.entry_index) >= RangeSlots);
  end

  always_comb begin
    out_o.kind = KIND_SEG;
    out_o.range_slot = 3'(act_q);
    out_o.segment_address = seg_addr_q;
    out_o.data_out = rdata;
    out_o.last = (rd_q + 1'b1 == fill_q);
  end
endmodule

/* hdl/arsb_ctrl.sv */
// Controller state machine sequencing requests through the datapath.
// Depends on arsb_pkg.
module arsb_ctrl import arsb_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  logic      out_ready_i,
  output logic      out_valid_o,
  output logic      load_res_o,
  output logic [1:0] load_kind_o,
  input  stat_t     stat_i,
  output ctrl_t     ctrl_o
);
  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_SEARCH, S_APPEND, S_CHECK, S_FLUSHPRE, S_FLUSH,
    S_LOADRES
  } state_e;

  // Where to go after a drain finishes.
  typedef enum logic [1:0] {
    N_DONE, N_CLOSE_SEARCH, N_APPEND, N_CHECK_END
  } next_e;

  state_e state_q;
  next_e nxt_q;
  logic [1:0] lkind_q;

  assign in_ready_o = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_FLUSH) || (state_q == S_LOADRES);
  assign load_res_o = (state_q == S_LOADRES);
  assign load_kind_o = lkind_q;

  always_comb begin
    ctrl_o = '0;
    ctrl_o.capture = (state_q == S_IDLE) && in_valid_i;
    unique case (state_q)
      S_DECODE: begin
        if (stat_i.cmd == CMD_DATA && !stat_i.table_bad && !stat_i.range_open) begin
          ctrl_o.search_init = 1'b1;
        end else if (stat_i.cmd == CMD_DATA && !stat_i.table_bad &&
                     !stat_i.addr_match && stat_i.fill_zero) begin
          ctrl_o.close_range = 1'b1;
          ctrl_o.search_init = 1'b1;
        end else if (stat_i.cmd == CMD_END && stat_i.fill_zero) begin
          ctrl_o.close_range = 1'b1;
        end else if (stat_i.cmd == CMD_LOAD && !stat_i.load_ignore) begin
          ctrl_o.set_bad = stat_i.load_bad;
          ctrl_o.load_commit = !stat_i.load_bad;
        end
      end
      S_SEARCH: begin
        ctrl_o.search_step = 1'b1;
        ctrl_o.open_range = stat_i.search_done && stat_i.search_hit;
      end
      S_APPEND: ctrl_o.append = !stat_i.full_before;
      S_CHECK: begin
        if ((stat_i.hit_limit || stat_i.range_end) && stat_i.fill_zero) begin
          ctrl_o.close_range = stat_i.range_end;
        end
      end
      // Segment address is captured in the cycle before the first byte is shown.
      S_FLUSHPRE: ctrl_o.flush_start = 1'b1;
      S_FLUSH: begin
        ctrl_o.flush_step = out_ready_i;
        ctrl_o.close_range = out_ready_i && stat_i.flush_last &&
          (nxt_q == N_CLOSE_SEARCH || nxt_q == N_DONE && stat_i.cmd == CMD_END ||
           nxt_q == N_CHECK_END);
        ctrl_o.search_init = out_ready_i && stat_i.flush_last && nxt_q == N_CLOSE_SEARCH;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      nxt_q <= N_DONE;
      lkind_q <= KIND_ACC;
    end else begin
      unique case (state_q)
        S_IDLE: if (in_valid_i) state_q <= S_DECODE;
        S_DECODE: begin
          state_q <= S_IDLE;
          if (stat_i.cmd == CMD_DATA && !stat_i.table_bad) begin
            if (!stat_i.range_open) state_q <= S_SEARCH;
            else if (stat_i.addr_match) state_q <= S_APPEND;
            else if (stat_i.fill_zero) state_q <= S_SEARCH;
            else begin
              nxt_q <= N_CLOSE_SEARCH;
              state_q <= S_FLUSHPRE;
            end
          end else if (stat_i.cmd == CMD_END && !stat_i.fill_zero &&
                       stat_i.range_open) begin
            nxt_q <= N_DONE;
            state_q <= S_FLUSHPRE;
          end else if (stat_i.cmd == CMD_LOAD && !stat_i.load_ignore) begin
            lkind_q <= stat_i.load_bad ? KIND_REJ : KIND_ACC;
            state_q <= S_LOADRES;
          end
        end
        S_SEARCH: if (stat_i.search_done) state_q <= stat_i.search_hit ? S_APPEND : S_IDLE;
        S_APPEND: begin
          if (stat_i.full_before) begin
            nxt_q <= N_APPEND;
            state_q <= S_FLUSHPRE;
          end else begin
            state_q <= S_CHECK;
          end
        end
        S_CHECK: begin
          if ((stat_i.hit_limit || stat_i.range_end) && !stat_i.fill_zero) begin
            nxt_q <= stat_i.range_end ? N_CHECK_END : N_DONE;
            state_q <= S_FLUSHPRE;
          end else begin
            state_q <= S_IDLE;
          end
        end
        S_FLUSHPRE: state_q <= S_FLUSH;
        S_FLUSH: begin
          if (out_ready_i && stat_i.flush_last) begin
            unique case (nxt_q)
              N_CLOSE_SEARCH: state_q <= S_SEARCH;
              N_APPEND: state_q <= S_APPEND;
              default: state_q <= S_IDLE;
            endcase
          end
        end
        S_LOADRES: if (out_ready_i) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_ready_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o) else $error("ready while a result is shown");
  a_capture_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> state_q == S_DECODE) else $error("request not decoded");
  a_flush_has_pre: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(state_q == S_FLUSH) |-> $past(state_q) == S_FLUSHPRE)
    else $error("drain without address capture");
endmodule

/* hdl/address_range_segment_buffer.sv */
// Top level of the address range segment buffer.
// Depends on arsb_pkg, arsb_ctrl and arsb_datapath.
//
// Requests enter on the in channel (valid/ready): data bytes, end of stream
// commands and range table loads. Results leave on the out channel: one
// result per load (accepted or rejected), and segment bytes in runs that end
// with last set. Configuration writes set the range count and buffer limit.
// A request is taken only while the block is idle, one at a time. A data
// byte inside an open range passes through decode, append and check before
// the next accept; a byte that opens a range first runs the sequential
// range search, one table slot per cycle up to the range count, and then
// acts on the outcome. A flush has a setup state, then one byte per cycle
// while the receiver is ready; a stalled receiver holds the current result
// and the controller waits. A load passes decode and a result state. Reset
// clears the written marks of the table, the bad flag, the open range and
// the fill count; configuration returns to one range and a limit of 32
// bytes. No clearing pass is needed after reset.
module address_range_segment_buffer import arsb_pkg::*; #(
  parameter int unsigned RANGE_SLOTS = 8,
  parameter int unsigned BUFFER_BYTES = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_item_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_item_t           out_data_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);
  logic [3:0] range_count_q;
  logic [5:0] buffer_limit_q;
  ctrl_t ctrl;
  stat_t stat;
  out_item_t seg;
  logic load_res;
  logic [1:0] load_kind;
  in_item_t req_view;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_count_q <= 4'd1;
      buffer_limit_q <= 6'd32;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_RANGE_COUNT: range_count_q <= cfg_data_i[3:0];
        CFG_BUFFER_LIMIT: buffer_limit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  arsb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .load_res_o  (load_res),
    .load_kind_o (load_kind),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  arsb_datapath #(.RangeSlots(RANGE_SLOTS), .BufferBytes(BUFFER_BYTES)) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_i           (in_data_i),
    .range_count_i  (range_count_q),
    .buffer_limit_i (buffer_limit_q),
    .ctrl_i         (ctrl),
    .stat_o         (stat),
    .out_o          (seg)
  );

  // Load results carry the slot of the captured load request.
  always_ff @(posedge clk_i) begin
    if (ctrl.capture) req_view <= in_data_i;
  end

  always_comb begin
    out_data_o = seg;
    if (load_res) begin
      out_data_o.kind = load_kind;
      out_data_o.range_slot = req_view.entry_index;
      out_data_o.segment_address = '0;
      out_data_o.data_out = '0;
      out_data_o.last = 1'b0;
    end
  end
endmodule

/* dv/testbench.sv */
// Self-checking testbench for address_range_segment_buffer.
// Depends on arsb_pkg and the block's RTL; a built-in predictor checks every result.
`timescale 1ns / 100ps

module testbench;
  import arsb_pkg::*;

  localparam int unsigned SLOTS = 8;
  localparam int unsigned BYTES = 32;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned SETTLE_CYCLES = 120;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  in_item_t            in_data_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  out_item_t           out_data_o;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  address_range_segment_buffer #(
    .RANGE_SLOTS (SLOTS),
    .BUFFER_BYTES(BYTES)
  ) u_top (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Predicted range table, segment state and registers.
  logic [31:0] slot_start [SLOTS];
  logic [31:0] slot_length [SLOTS];
  logic        slot_relative [SLOTS];
  logic        slot_loaded [SLOTS];
  logic        table_is_bad;
  logic        range_is_open;
  logic [2:0]  open_slot;
  logic [31:0] open_offset;
  int unsigned gathered;
  logic [7:0]  gathered_bytes [BYTES];
  int unsigned range_count_reg;
  int unsigned buffer_limit_reg;

  out_item_t   pending_outputs[$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic [31:0] table_top;

  function automatic void push_output(logic [1:0] kind, logic [2:0] slot, logic [31:0] addr,
                                      logic [7:0] data, logic last);
    out_item_t o;
    o.kind = kind;
    o.range_slot = slot;
    o.segment_address = addr;
    o.data_out = data;
    o.last = last;
    pending_outputs.push_back(o);
  endfunction

  function automatic void flush_gathered();
    logic [31:0] addr;
    addr = open_offset - gathered;
    if (!range_is_open || gathered == 0) return;
    if (!slot_relative[open_slot]) addr += slot_start[open_slot];
    for (int unsigned k = 0; k < gathered; k++)
      push_output(KIND_SEG, open_slot, addr, gathered_bytes[k], k + 1 == gathered);
    gathered = 0;
  endfunction

  function automatic void close_open_range();
    range_is_open = 1'b0;
    open_slot = '0;
    open_offset = '0;
    gathered = 0;
  endfunction

  function automatic void take_data_byte(logic [31:0] addr, logic [7:0] data);
    int unsigned cnt, idx, lim;
    cnt = (range_count_reg > SLOTS) ? SLOTS : range_count_reg;
    lim = (buffer_limit_reg == 0) ? 1 : ((buffer_limit_reg > BYTES) ? BYTES : buffer_limit_reg);
    if (table_is_bad) return;
    if (range_is_open && {32'd0, addr} != {32'd0, slot_start[open_slot]} + open_offset) begin
      flush_gathered();
      close_open_range();
    end
    if (!range_is_open) begin
      for (idx = 0; idx < cnt; idx++)
        if ({32'd0, slot_start[idx]} + slot_length[idx] > {32'd0, addr}) break;
      if (idx >= cnt || slot_start[idx] > addr) return;
      range_is_open = 1'b1;
      open_slot = idx[2:0];
      open_offset = addr - slot_start[idx];
      gathered = 0;
    end
    if (gathered >= BYTES) flush_gathered();
    gathered_bytes[gathered] = data;
    gathered++;
    open_offset++;
    if (gathered >= lim || open_offset == slot_length[open_slot]) begin
      flush_gathered();
      if (open_offset == slot_length[open_slot]) close_open_range();
    end
  endfunction

  function automatic void take_load(logic [2:0] i, logic [31:0] s, logic [31:0] l, logic rel);
    logic bad;
    bad = 1'b0;
    if (i > 0 && slot_loaded[i-1])
      if (slot_start[i-1] >= s || {32'd0, slot_start[i-1]} + slot_length[i-1] > {32'd0, s})
        bad = 1'b1;
    if (i < SLOTS - 1 && slot_loaded[i+1])
      if (s >= slot_start[i+1] || {32'd0, s} + l > {32'd0, slot_start[i+1]})
        bad = 1'b1;
    if (bad) begin
      table_is_bad = 1'b1;
      push_output(KIND_REJ, i, '0, '0, 1'b0);
      return;
    end
    slot_start[i] = s;
    slot_length[i] = l;
    slot_relative[i] = rel;
    slot_loaded[i] = 1'b1;
    push_output(KIND_ACC, i, '0, '0, 1'b0);
  endfunction

  function automatic void predict_request(in_item_t it);
    case (it.cmd)
      CMD_DATA: take_data_byte(it.address, it.data_byte);
      CMD_END: begin
        flush_gathered();
        close_open_range();
      end
      CMD_LOAD: take_load(it.entry_index, it.entry_start, it.entry_length, it.entry_relative);
      default: ;
    endcase
  endfunction

  // Result checker and receiver stalls.
  always @(posedge clk_i) begin
    out_item_t exp_item;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_outputs.size() == 0) begin
        $error("unexpected result kind=%0d slot=%0d", out_data_o.kind, out_data_o.range_slot);
        errors++;
      end else begin
        exp_item = pending_outputs.pop_front();
        if (out_data_o.kind !== exp_item.kind) begin
          $error("kind: expected %0d, got %0d", exp_item.kind, out_data_o.kind);
          errors++;
        end
        if (out_data_o.range_slot !== exp_item.range_slot) begin
          $error("range_slot: expected %0d, got %0d", exp_item.range_slot, out_data_o.range_slot);
          errors++;
        end
        if (out_data_o.segment_address !== exp_item.segment_address) begin
          $error("segment_address: expected %h, got %h", exp_item.segment_address,
                 out_data_o.segment_address);
          errors++;
        end
        if (out_data_o.data_out !== exp_item.data_out) begin
          $error("data_out: expected %h, got %h", exp_item.data_out, out_data_o.data_out);
          errors++;
        end
        if (out_data_o.last !== exp_item.last) begin
          $error("last: expected %0d, got %0d", exp_item.last, out_data_o.last);
          errors++;
        end
      end
    end
    out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("address_range_segment_buffer verification failed");
      $finish;
    end
  end

  function automatic in_item_t random_request(logic [1:0] cmd);
    in_item_t it;
    it.cmd = cmd;
    it.address = $urandom;
    it.data_byte = 8'($urandom);
    it.entry_index = 3'($urandom);
    it.entry_start = $urandom;
    it.entry_length = $urandom;
    it.entry_relative = 1'($urandom);
    return it;
  endfunction

  task automatic send_request(in_item_t it);
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (!in_ready_o);
    predict_request(it);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic send_data(logic [31:0] addr);
    in_item_t it;
    it = random_request(CMD_DATA);
    it.address = addr;
    send_request(it);
  endtask

  task automatic send_load(logic [2:0] i, logic [31:0] s, logic [31:0] l, logic rel);
    in_item_t it;
    it = random_request(CMD_LOAD);
    it.entry_index = i;
    it.entry_start = s;
    it.entry_length = l;
    it.entry_relative = rel;
    send_request(it);
  endtask

  // The sender holds off until every predicted result has been seen.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_outputs.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, int unsigned value);
    wait_drained();
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value[CfgDataW-1:0];
    @(posedge clk_i);
    if (idx == CFG_RANGE_COUNT) range_count_reg = value & 4'hf;
    else buffer_limit_reg = value & 6'h3f;
    cfg_we_i <= 1'b0;
  endtask

  // Moves the whole table above its current top; loading from the highest slot down
  // keeps every load consistent with its old neighbors.
  task automatic move_table(logic [31:0] base);
    logic [31:0] starts [SLOTS];
    logic [31:0] lengths [SLOTS];
    logic [31:0] cursor;
    cursor = base;
    for (int i = 0; i < SLOTS; i++) begin
      starts[i] = cursor;
      lengths[i] = $urandom_range(1, 40);
      cursor += lengths[i] + $urandom_range(0, 12);
    end
    for (int i = SLOTS - 1; i >= 0; i--)
      send_load(i[2:0], starts[i], lengths[i], 1'($urandom_range(0, 1)));
    table_top = cursor;
  endtask

  task automatic test_directed();
    write_reg(CFG_RANGE_COUNT, 8);
    for (int i = SLOTS - 1; i >= 0; i--)
      send_load(i[2:0], i * 16, 8, i[0]);
    send_request(random_request(CMD_END));   // empty buffer flushes nothing
    send_request(random_request(2'd3));      // unknown command
    send_data(32'd15);                       // leading byte before slot 1 is dropped
    send_data(32'd16);
    send_data(32'd17);
    send_load(3'd5, 32'd80, 32'd8, 1'b1);    // reload must not disturb the open segment
    send_data(32'd18);
    send_data(32'd20);                       // address gap flushes three bytes
    for (int a = 21; a < 24; a++) send_data(a);
    send_data(32'd0);
    send_data(32'd1);
    send_request(random_request(CMD_END));
    write_reg(CFG_BUFFER_LIMIT, 1);
    for (int a = 32; a < 35; a++) send_data(a);
    write_reg(CFG_BUFFER_LIMIT, 32);
    table_top = 32'd200;
  endtask

  task automatic test_random(int unsigned count);
    int unsigned sent, slot, run;
    logic [31:0] addr;
    sent = 0;
    while (sent < count) begin
      case ($urandom_range(0, 19))
        0, 1: begin
          send_request(random_request(CMD_END));
          sent++;
        end
        2: begin
          slot = $urandom_range(0, SLOTS - 1);
          send_load(slot[2:0], slot_start[slot], slot_length[slot], slot_relative[slot]);
          sent++;
        end
        3: begin
          send_request(random_request(2'd3));
        end
        4: begin
          send_data($urandom);
          sent++;
        end
        default: begin
          slot = $urandom_range(0, SLOTS - 1);
          addr = slot_start[slot] + $urandom_range(0, slot_length[slot] + 1);
          if ($urandom_range(0, 3) == 0) addr = slot_start[slot];
          run = $urandom_range(1, 14);
          for (int k = 0; k < run; k++) send_data(addr + k);
          sent += run;
        end
      endcase
    end
  endtask

  task automatic test_table_top();
    wait_drained();
    for (int i = SLOTS - 1; i >= 0; i--)
      send_load(i[2:0], (i == SLOTS - 1) ? 32'hffff_ff00 : 32'hffff_fe00 + i * 32,
                (i == SLOTS - 1) ? 32'hffff_ffff : 32'd16, i[0]);
    write_reg(CFG_RANGE_COUNT, 15);           // above the slot count acts as all slots
    for (logic [32:0] a = 33'h0_ffff_fffc; a <= 33'h0_ffff_ffff; a++) send_data(a[31:0]);
    send_data(32'd0);
    send_data(32'hffff_fe20);
    send_data(32'hffff_fe21);
    send_load(3'd3, 32'd0, 32'hffff_ffff, 1'b1); // overlap marks the table bad
    send_data(32'hffff_fe22);                    // ignored from now on
    send_request(random_request(CMD_END));       // still flushes the partial segment
    send_load(3'd6, 32'hffff_fec0, 32'd16, 1'b0);
    send_request(random_request(CMD_END));
  endtask

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      slot_start[i] = '0;
      slot_length[i] = '0;
      slot_relative[i] = 1'b0;
      slot_loaded[i] = 1'b0;
    end
    table_is_bad = 1'b0;
    close_open_range();
    range_count_reg = 1;
    buffer_limit_reg = 32;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random(100);
    send_idle_pct = 60;
    write_reg(CFG_BUFFER_LIMIT, 7);
    write_reg(CFG_RANGE_COUNT, 5);
    move_table(table_top + $urandom_range(1, 5000));
    test_random(90);
    send_idle_pct = 0;
    recv_stall_pct = 60;
    write_reg(CFG_BUFFER_LIMIT, 0);
    write_reg(CFG_RANGE_COUNT, 8);
    move_table(table_top + $urandom_range(1, 5000));
    test_random(70);
    write_reg(CFG_BUFFER_LIMIT, 63);
    test_random(50);
    send_idle_pct = 13;
    recv_stall_pct = 13;
    write_reg(CFG_RANGE_COUNT, 0);            // no range in use: all data is dropped
    test_random(15);
    write_reg(CFG_RANGE_COUNT, 3);
    write_reg(CFG_BUFFER_LIMIT, $urandom_range(2, 31));
    move_table(32'h8000_0000 + $urandom_range(0, 32'h0fff_ffff));
    test_random(70);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_table_top();

    wait_drained();
    if (errors == 0 && pending_outputs.size() == 0)
      $display("address_range_segment_buffer verification clean");
    else
      $display("address_range_segment_buffer verification failed");
    $finish;
  end

endmodule
